// ===== rtl/node_id_compaction_renumber_core_assert.svh =====
// ----------------------------------------------------------------------------
// Node id compaction assertion macros
// Shared forms for the concurrent checks of the renumbering core.
// ----------------------------------------------------------------------------
`ifndef NODE_ID_COMPACTION_RENUMBER_CORE_ASSERT_SVH
`define NODE_ID_COMPACTION_RENUMBER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NIDC_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("nidc check failed");

// Consequent must hold in the cycle after the antecedent.
`define NIDC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("nidc check failed");

`endif

// ===== rtl/nidc_pkg.sv =====
// ----------------------------------------------------------------------------
// Node id compaction package
// Item field widths, operation codes, sequencer states and item structs.
// ----------------------------------------------------------------------------
`default_nettype none

package nidc_pkg;

  localparam int FUNC_W    = 2;
  localparam int NODE_ID_W = 16;
  localparam int POS_W     = 10;
  localparam int UCNT_W    = 11;
  localparam int LIDX_W    = 10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_FINISH = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_QRY     = 11'b000_0000_0010,
    S_INS_LD  = 11'b000_0000_0100,
    S_INS_CMP = 11'b000_0000_1000,
    S_INS_PUT = 11'b000_0001_0000,
    S_DD_RD   = 11'b000_0010_0000,
    S_DD_WR   = 11'b000_0100_0000,
    S_RK_LD   = 11'b000_1000_0000,
    S_RK_MID  = 11'b001_0000_0000,
    S_RK_CMP  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    func_t                func;
    logic [NODE_ID_W-1:0] node_id;
    logic [POS_W-1:0]     position;
  } req_t;

  typedef struct packed {
    logic                 slot_valid;
    logic [NODE_ID_W-1:0] slot_global_id;
    logic                 entry_valid;
    logic [LIDX_W-1:0]    local_index;
    logic                 overflow;
    logic [UCNT_W-1:0]    unique_count;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/node_id_compaction_renumber_core.sv =====
// ----------------------------------------------------------------------------
// Node id compaction and renumbering core
// Collects global node ids, sorts and deduplicates them on finish, and answers
// position queries with local numbers and unique-slot ids.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel; tuser carries the operation: append,
// finish or query. Appends are taken one per cycle and give no result.
// A query gives one result on the m_ channel, registered through the S_QRY
// state and then the output register; s_tready is low while in S_QRY.
// A finish runs an insertion sort, a dedup pass and a binary-search rank pass
// on comparators of sorted against entry ids, with single-port reads of the id memories.
// For N loaded entries the number S of insertion shifts reaches N * (N - 1) / 2
// for a reversed list; the finish result follows when the passes end.
// While a finish runs, s_tready stays low.
// Reset clears the counts and flags; the memory contents are not cleared and
// are only read behind valid flags. A result waits in the output register
// while m_tready is low; no new item of any kind is then accepted until that
// result is taken, and no result is ever dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "node_id_compaction_renumber_core_assert.svh"

module node_id_compaction_renumber_core
  import nidc_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int ID_BITS     = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,  // node_id [15:0], position [25:16], zero fill
  input  wire  [1:0]  s_tuser,  // func [1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata   // unique_count, overflow, local_index,
                                // entry_valid, slot_global_id, slot_valid
);

  logic eng_idle;
  logic eng_res_valid;
  logic in_acc;
  req_t req;
  res_t eng_res;
  res_t out_res;

  assign req.func     = func_t'(s_tuser);
  assign req.node_id  = s_tdata[15:0];
  assign req.position = s_tdata[25:16];

  assign s_tready = eng_idle && (!m_tvalid || m_tready);
  assign in_acc   = s_tvalid && s_tready;

  nidc_engine #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ID_BITS     (ID_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_acc),
    .req       (req),
    .idle      (eng_idle),
    .res_valid (eng_res_valid),
    .res       (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eng_res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid) begin
      out_res <= eng_res;
    end
  end

  assign m_tdata = out_res;

  `NIDC_ASSERT_SAME(a_no_result_overrun, clk, rst, eng_res_valid, !m_tvalid)
  `NIDC_ASSERT_NEXT(a_query_answers, clk, rst, in_acc && (req.func == FUNC_QUERY), eng_res_valid)

endmodule

`default_nettype wire

// ===== rtl/nidc_engine.sv =====
// ----------------------------------------------------------------------------
// Node id compaction engine
// Entry, sorted and local-number memories with the sort, dedup and rank
// sequencer around the id comparators.
// ----------------------------------------------------------------------------
`default_nettype none

`include "node_id_compaction_renumber_core_assert.svh"

module nidc_engine
  import nidc_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int ID_BITS     = 16
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  input  req_t req,
  output logic idle,
  output logic res_valid,
  output res_t res
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = CW + 1;
  localparam int EW = (CW > POS_W) ? CW : POS_W;

  logic [ID_BITS-1:0] ent_mem [MAX_ENTRIES];
  logic [ID_BITS-1:0] srt_mem [MAX_ENTRIES];
  logic [AW-1:0]      loc_mem [MAX_ENTRIES];

  state_t state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] dcnt;
  logic          ovf;
  logic          fin;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] n;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [AW-1:0] mid;
  logic [ID_BITS-1:0] last;
  logic          q_ev;
  logic          q_sv;

  logic               ent_we;
  logic [AW-1:0]      ent_waddr;
  logic               ent_re;
  logic [AW-1:0]      ent_raddr;
  logic [ID_BITS-1:0] ent_rdata;
  logic               srt_we;
  logic [AW-1:0]      srt_waddr;
  logic [ID_BITS-1:0] srt_wdata;
  logic [AW-1:0]      srt_raddr;
  logic [ID_BITS-1:0] srt_rdata;
  logic               loc_we;
  logic [AW-1:0]      loc_rdata;
  logic [SW-1:0]      mid_sum;
  logic [AW-1:0]      mid_c;
  logic               cmp_gt;
  logic               cmp_lt;
  logic               has_room;
  logic               is_new;

  assign idle     = (state == S_IDLE);
  assign has_room = (cnt < CW'(MAX_ENTRIES));
  assign cmp_gt   = (srt_rdata > ent_rdata);
  assign cmp_lt   = (srt_rdata < ent_rdata);
  assign mid_sum  = SW'(lo) + SW'(hi);
  assign mid_c    = mid_sum[AW:1];
  assign is_new   = (n == '0) || (last != srt_rdata);

  assign ent_we    = idle && req_valid && (req.func == FUNC_APPEND) && (fin || has_room);
  assign ent_waddr = fin ? '0 : AW'(cnt);
  assign ent_re    = (state == S_INS_LD) || (state == S_RK_LD);
  assign ent_raddr = AW'(i);
  assign loc_we    = (state == S_RK_MID) && !(lo < hi);

  always_comb begin
    srt_raddr = '0;
    srt_we    = 1'b0;
    srt_waddr = AW'(j);
    srt_wdata = ent_rdata;
    unique case (state)
      S_IDLE:    srt_raddr = AW'(req.position);
      S_INS_LD:  srt_raddr = AW'(i - CW'(1));
      S_INS_CMP: begin
        srt_raddr = AW'(j - CW'(2));
        srt_we    = 1'b1;
        srt_wdata = cmp_gt ? srt_rdata : ent_rdata;
      end
      S_INS_PUT: begin
        srt_we    = 1'b1;
        srt_waddr = '0;
      end
      S_DD_RD:   srt_raddr = AW'(i);
      S_DD_WR:   begin
        srt_we    = is_new;
        srt_waddr = AW'(n);
        srt_wdata = srt_rdata;
      end
      S_RK_MID:  srt_raddr = mid_c;
      default:   srt_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ID_BITS'(req.node_id);
    end
    if (ent_re) begin
      ent_rdata <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
    srt_rdata <= srt_mem[srt_raddr];
  end

  always_ff @(posedge clk) begin
    if (loc_we) begin
      loc_mem[AW'(i)] <= AW'(lo);
    end
    loc_rdata <= loc_mem[AW'(req.position)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      dcnt  <= '0;
      ovf   <= 1'b0;
      fin   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            case (req.func)
              FUNC_APPEND: begin
                if (fin) begin
                  cnt  <= CW'(1);
                  dcnt <= '0;
                  ovf  <= 1'b0;
                  fin  <= 1'b0;
                end else if (has_room) begin
                  cnt <= cnt + CW'(1);
                end else begin
                  ovf <= 1'b1;
                end
              end
              FUNC_FINISH: begin
                i     <= '0;
                state <= S_INS_LD;
              end
              FUNC_QUERY: begin
                q_ev  <= fin && (EW'(req.position) < EW'(cnt));
                q_sv  <= fin && (EW'(req.position) < EW'(dcnt));
                state <= S_QRY;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_QRY: state <= S_IDLE;
        S_INS_LD: begin
          if (i == cnt) begin
            i     <= '0;
            n     <= '0;
            state <= S_DD_RD;
          end else begin
            j     <= i;
            state <= (i == '0) ? S_INS_PUT : S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (cmp_gt) begin
            j <= j - CW'(1);
            if (j == CW'(1)) begin
              state <= S_INS_PUT;
            end
          end else begin
            i     <= i + CW'(1);
            state <= S_INS_LD;
          end
        end
        S_INS_PUT: begin
          i     <= i + CW'(1);
          state <= S_INS_LD;
        end
        S_DD_RD: begin
          if (i == cnt) begin
            i     <= '0;
            state <= S_RK_LD;
          end else begin
            state <= S_DD_WR;
          end
        end
        S_DD_WR: begin
          if (is_new) begin
            last <= srt_rdata;
            n    <= n + CW'(1);
          end
          i     <= i + CW'(1);
          state <= S_DD_RD;
        end
        S_RK_LD: begin
          if (i == cnt) begin
            state <= S_DONE;
          end else begin
            lo    <= '0;
            hi    <= n;
            state <= S_RK_MID;
          end
        end
        S_RK_MID: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= S_RK_CMP;
          end else begin
            i     <= i + CW'(1);
            state <= S_RK_LD;
          end
        end
        S_RK_CMP: begin
          if (cmp_lt) begin
            lo <= CW'(mid) + CW'(1);
          end else begin
            hi <= CW'(mid);
          end
          state <= S_RK_MID;
        end
        S_DONE: begin
          dcnt  <= n;
          fin   <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res_valid          = (state == S_QRY) || (state == S_DONE);
    res.overflow       = ovf;
    res.local_index    = '0;
    res.entry_valid    = 1'b0;
    res.slot_global_id = '0;
    res.slot_valid     = 1'b0;
    if (state == S_DONE) begin
      res.unique_count = UCNT_W'(n);
    end else begin
      res.unique_count   = fin ? UCNT_W'(dcnt) : '0;
      res.local_index    = q_ev ? LIDX_W'(loc_rdata) : '0;
      res.entry_valid    = q_ev;
      res.slot_global_id = q_sv ? NODE_ID_W'(srt_rdata) : '0;
      res.slot_valid     = q_sv;
    end
  end

  `NIDC_ASSERT_NEXT(a_query_one_cycle, clk, rst, state == S_QRY, state == S_IDLE)
  `NIDC_ASSERT_SAME(a_search_bounds, clk, rst, state == S_RK_MID, (lo <= hi) && (hi <= n))
  `NIDC_ASSERT_SAME(a_distinct_le_entries, clk, rst, state == S_DONE, n <= cnt)

endmodule

`default_nettype wire
